FILE: rtl/ips_patch_stream_parser_macros.svh
// Assertion macros used by the parser's checker.
`ifndef IPS_PATCH_STREAM_PARSER_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define IPSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Next-cycle implication, disabled in reset.
`define IPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

FILE: rtl/ipsp_pkg.sv
// Types, status codes and header bytes of the IPS patch stream parser.
`default_nettype none

package ipsp_pkg;

  localparam int unsigned AddrW   = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] StRunning = 3'd0;
  localparam logic [StatusW-1:0] StOk      = 3'd1;
  localparam logic [StatusW-1:0] StBadHdr  = 3'd2;
  localparam logic [StatusW-1:0] StTrunc   = 3'd3;
  localparam logic [StatusW-1:0] StNoEof   = 3'd4;

  typedef enum logic [1:0] {
    CmdNone,
    CmdLiteral,
    CmdFill
  } ipsp_kind_e;

  typedef struct packed {
    ipsp_kind_e          kind;
    logic [AddrW-1:0]    address;
    logic [ByteW-1:0]    value;
    logic [CountW-1:0]   count;
    logic [StatusW-1:0]  status;
  } ipsp_cmd_t;

  function automatic logic [ByteW-1:0] hdr_byte(input logic [2:0] idx);
    logic [ByteW-1:0] res;
    unique case (idx)
      3'd0:    res = 8'h50;
      3'd1:    res = 8'h41;
      3'd2:    res = 8'h54;
      3'd3:    res = 8'h43;
      3'd4:    res = 8'h48;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ipsp_if.sv
// Stream interfaces of the parser: patch bytes in, write commands out.
`default_nettype none

interface ipsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       final_byte;

  modport source (output valid, output patch_byte, output final_byte, input ready);
  modport sink   (input valid, input patch_byte, input final_byte, output ready);
endinterface

interface ipsp_out_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [23:0] write_address;
  logic [7:0]  write_value;
  logic [15:0] fill_count;
  logic [2:0]  status;

  modport source (output valid, output write_valid, output write_address,
                  output write_value, output fill_count, output status, input ready);
  modport sink   (input valid, input write_valid, input write_address,
                  input write_value, input fill_count, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/ips_patch_stream_parser.sv
// IPS patch stream parser top level: front end, command queue and output stage.
// Each byte's result is pushed into the queue, then registered in the output stage for cmd_o.
// Throughput: one byte per cycle while the queue has room, set by the front-end parser.
// The queue absorbs QueueDepth bytes while cmd_o stalls, then patch_i.ready drops.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase with status
// running, empties the queue and drops cmd_o.valid.
`default_nettype none

module ips_patch_stream_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ipsp_in_if.sink    patch_i,
  ipsp_out_if.source cmd_o
);

  ipsp_pkg::ipsp_cmd_t push_data;
  ipsp_pkg::ipsp_cmd_t pop_data;
  logic                push;
  logic                full;
  logic                pop;
  logic                empty;

  ipsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .patch_i     (patch_i),
    .full_i      (full),
    .push_data_o (push_data),
    .push_o      (push)
  );

  ipsp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  ipsp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .cmd_o      (cmd_o)
  );

endmodule

`default_nettype wire

FILE: rtl/ipsp_front.sv
// Front end: accepts patch bytes, runs the record parser, emits compact commands.
`default_nettype none

module ipsp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ipsp_in_if.sink            patch_i,
  input  wire logic          full_i,
  output ipsp_pkg::ipsp_cmd_t push_data_o,
  output logic               push_o
);

  localparam logic [2:0] PhHeader   = 3'd0;
  localparam logic [2:0] PhOffset   = 3'd1;
  localparam logic [2:0] PhSize     = 3'd2;
  localparam logic [2:0] PhData     = 3'd3;
  localparam logic [2:0] PhRleCount = 3'd4;
  localparam logic [2:0] PhRleValue = 3'd5;
  localparam logic [2:0] PhDone     = 3'd6;

  logic [2:0]                      phase_q, phase_d;
  logic [2:0]                      idx_q, idx_d;
  logic [ipsp_pkg::AddrW-1:0]      off_q, off_d;
  logic [ipsp_pkg::CountW-1:0]     len_q, len_d;
  logic                            eof_q, eof_d;
  logic [ipsp_pkg::StatusW-1:0]    status_q, status_d;

  logic                            xfer;
  logic [7:0]                      b;
  logic                            last;
  logic [ipsp_pkg::AddrW-1:0]      off_shift;
  logic [ipsp_pkg::CountW-1:0]     len_shift;
  logic [ipsp_pkg::CountW-1:0]     len_dec;
  logic                            eof_next;
  logic                            fin;
  logic [ipsp_pkg::StatusW-1:0]    fin_st;
  ipsp_pkg::ipsp_kind_e            kind;

  assign patch_i.ready = !full_i;
  assign xfer          = patch_i.valid && !full_i;
  assign b             = patch_i.patch_byte;
  assign last          = patch_i.final_byte;

  assign off_shift = (idx_q == 3'd0) ? {16'h0000, b} : {off_q[15:0], b};
  assign len_shift = (idx_q == 3'd0) ? {8'h00, b} : {len_q[7:0], b};
  assign len_dec   = (len_q != '0) ? len_q - 16'd1 : '0;

  always_comb begin
    priority if (idx_q == 3'd0) begin
      eof_next = (b == 8'h45);
    end else if (idx_q == 3'd1) begin
      eof_next = eof_q && (b == 8'h4F);
    end else begin
      eof_next = eof_q && (b == 8'h46);
    end
  end

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    off_d    = off_q;
    len_d    = len_q;
    eof_d    = eof_q;
    status_d = status_q;
    kind     = ipsp_pkg::CmdNone;
    fin      = 1'b0;
    fin_st   = status_q;
    unique case (phase_q)
      PhHeader: begin
        if (idx_q > 3'd4 || b != ipsp_pkg::hdr_byte(idx_q)) begin
          fin    = 1'b1;
          fin_st = ipsp_pkg::StBadHdr;
        end else if (idx_q == 3'd4) begin
          idx_d   = 3'd0;
          phase_d = PhOffset;
          if (last) begin
            fin    = 1'b1;
            fin_st = ipsp_pkg::StNoEof;
          end
        end else begin
          idx_d = idx_q + 3'd1;
          if (last) begin
            fin    = 1'b1;
            fin_st = ipsp_pkg::StBadHdr;
          end
        end
      end
      PhOffset: begin
        off_d = off_shift;
        eof_d = eof_next;
        if (idx_q >= 3'd2) begin
          idx_d = 3'd0;
          if (eof_next) begin
            fin    = 1'b1;
            fin_st = ipsp_pkg::StOk;
          end else begin
            phase_d = PhSize;
            if (last) begin
              fin    = 1'b1;
              fin_st = ipsp_pkg::StTrunc;
            end
          end
        end else begin
          idx_d = idx_q + 3'd1;
          if (last) begin
            fin    = 1'b1;
            fin_st = ipsp_pkg::StNoEof;
          end
        end
      end
      PhSize: begin
        len_d = len_shift;
        if (idx_q == 3'd0) begin
          idx_d = 3'd1;
        end else begin
          idx_d   = 3'd0;
          phase_d = (len_shift != '0) ? PhData : PhRleCount;
        end
        if (last) begin
          fin    = 1'b1;
          fin_st = ipsp_pkg::StTrunc;
        end
      end
      PhData: begin
        if (last && len_q > 16'd1) begin
          fin    = 1'b1;
          fin_st = ipsp_pkg::StTrunc;
        end else begin
          kind  = ipsp_pkg::CmdLiteral;
          off_d = off_q + 24'd1;
          len_d = len_dec;
          if (len_dec == '0) begin
            phase_d = PhOffset;
          end
          if (last) begin
            fin    = 1'b1;
            fin_st = ipsp_pkg::StNoEof;
          end
        end
      end
      PhRleCount: begin
        len_d = len_shift;
        if (idx_q == 3'd0) begin
          idx_d = 3'd1;
        end else begin
          idx_d   = 3'd0;
          phase_d = PhRleValue;
        end
        if (last) begin
          fin    = 1'b1;
          fin_st = ipsp_pkg::StTrunc;
        end
      end
      PhRleValue: begin
        if (len_q != '0) begin
          kind = ipsp_pkg::CmdFill;
        end
        phase_d = PhOffset;
        idx_d   = 3'd0;
        if (last) begin
          fin    = 1'b1;
          fin_st = ipsp_pkg::StNoEof;
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      status_d = fin_st;
      phase_d  = PhDone;
    end
  end

  assign push_o              = xfer;
  assign push_data_o.kind    = kind;
  assign push_data_o.address = off_q;
  assign push_data_o.value   = b;
  assign push_data_o.count   = len_q;
  assign push_data_o.status  = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      idx_q    <= 3'd0;
      off_q    <= '0;
      len_q    <= '0;
      eof_q    <= 1'b0;
      status_q <= ipsp_pkg::StRunning;
    end else if (xfer) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      off_q    <= off_d;
      len_q    <= len_d;
      eof_q    <= eof_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ipsp_fifo.sv
// Command queue between the parser front end and the output stage.
`default_nettype none

module ipsp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ipsp_pkg::ipsp_cmd_t  push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output ipsp_pkg::ipsp_cmd_t       pop_data_o,
  output logic                      empty_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ipsp_pkg::ipsp_cmd_t mem_q [Depth];
  logic [IdxW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ipsp_back.sv
// Back end: turns queued commands into result items and holds them for the sink.
`default_nettype none

module ipsp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ipsp_pkg::ipsp_cmd_t pop_data_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  ipsp_out_if.source               cmd_o
);

  logic                            vld_q;
  logic                            wv_q, wv_d;
  logic [ipsp_pkg::AddrW-1:0]      addr_q, addr_d;
  logic [ipsp_pkg::ByteW-1:0]      val_q, val_d;
  logic [ipsp_pkg::CountW-1:0]     cnt_q, cnt_d;
  logic [ipsp_pkg::StatusW-1:0]    st_q;

  assign pop_o = !empty_i && (!vld_q || cmd_o.ready);

  always_comb begin
    unique case (pop_data_i.kind)
      ipsp_pkg::CmdLiteral: begin
        wv_d   = 1'b1;
        addr_d = pop_data_i.address;
        val_d  = pop_data_i.value;
        cnt_d  = 16'd1;
      end
      ipsp_pkg::CmdFill: begin
        wv_d   = 1'b1;
        addr_d = pop_data_i.address;
        val_d  = pop_data_i.value;
        cnt_d  = pop_data_i.count;
      end
      default: begin
        wv_d   = 1'b0;
        addr_d = '0;
        val_d  = '0;
        cnt_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (cmd_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wv_q   <= wv_d;
      addr_q <= addr_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
      st_q   <= pop_data_i.status;
    end
  end

  assign cmd_o.valid         = vld_q;
  assign cmd_o.write_valid   = wv_q;
  assign cmd_o.write_address = addr_q;
  assign cmd_o.write_value   = val_q;
  assign cmd_o.fill_count    = cnt_q;
  assign cmd_o.status        = st_q;

endmodule

`default_nettype wire

FILE: rtl/ipsp_checker.sv
// Port-level checker for the IPS patch stream parser and its bind.
`default_nettype none
`include "ips_patch_stream_parser_macros.svh"

module ipsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        write_valid_i,
  input wire logic [23:0] write_address_i,
  input wire logic [7:0]  write_value_i,
  input wire logic [15:0] fill_count_i,
  input wire logic [2:0]  status_i
);

  logic       out_xfer;
  logic [2:0] last_st_q;

  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_st_q <= ipsp_pkg::StRunning;
    end else if (out_xfer) begin
      last_st_q <= status_i;
    end
  end

  `IPSP_ASSERT_IMPLY(a_status_sticky, clk_i, rst_ni,
    out_valid_i && last_st_q != ipsp_pkg::StRunning, status_i == last_st_q)

  `IPSP_ASSERT_IMPLY(a_idle_fields_zero, clk_i, rst_ni, out_valid_i && !write_valid_i,
    write_address_i == '0 && write_value_i == '0 && fill_count_i == '0)

  `IPSP_ASSERT_IMPLY(a_write_count_nonzero, clk_i, rst_ni,
    out_valid_i && write_valid_i, fill_count_i != '0)

  `IPSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(status_i) && $stable(write_address_i))

endmodule

bind ips_patch_stream_parser ipsp_checker u_ipsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (cmd_o.valid),
  .out_ready_i     (cmd_o.ready),
  .write_valid_i   (cmd_o.write_valid),
  .write_address_i (cmd_o.write_address),
  .write_value_i   (cmd_o.write_value),
  .fill_count_i    (cmd_o.fill_count),
  .status_i        (cmd_o.status)
);

`default_nettype wire
